@@ rtl/stsi_pkg.sv @@
// Package for the sorted table: field widths, request and status codes, cell types.
`timescale 1ns / 1ps

package stsi_pkg;

    // Default table depth
    localparam int DEF_CAPACITY = 128;

    // Fixed field widths
    localparam int REQ_W   = 2;
    localparam int VAL_W   = 32;
    localparam int STAT_W  = 2;
    localparam int POS_W   = 7;
    localparam int COUNT_W = 8;

    // Request kinds (any other code is handled as a search)
    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_DELETE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_SEARCH = 2'd2;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STAT_W-1:0] ST_MISSING = 2'd2;

    // Broadcast control to every cell
    typedef struct packed {
        logic                    cmp_en;
        logic                    is_ins;
        logic                    shift_ins;
        logic                    shift_del;
        logic signed [VAL_W-1:0] value;
    } t_cell_ctrl;

    // Flags a cell shows to its neighbours and to the top level
    typedef struct packed {
        logic lt;
        logic le;
        logic hot;
        logic match;
    } t_cell_stat;

endpackage

@@ rtl/sorted_table_insert_delete_search.sv @@
// Top level of the sorted table: request sequencer, cell row and result registers.
`timescale 1ns / 1ps

// Keeps up to CAPACITY signed values in ascending order in a row of cells, one
// entry per cell. A request is taken when start is high and busy is low; busy
// then stays high through the compare, encode, shift and result phases, and the
// result appears on the o_ ports with o_valid high for exactly one cycle, the
// cycle in which busy has fallen again, so a new request may be started in that
// same cycle. Every request runs through all four steps of the sequencer,
// whatever the table size. The receiver cannot stall: each result
// must be captured in its strobe cycle. Position and count report the low 7 and
// 8 bits of the true index and count.
module sorted_table_insert_delete_search #(
    parameter int CAPACITY = stsi_pkg::DEF_CAPACITY
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [stsi_pkg::REQ_W-1:0]          i_req_type,
    input  logic signed [stsi_pkg::VAL_W-1:0]   i_value,
    output logic                                o_valid,
    output logic [stsi_pkg::STAT_W-1:0]         o_status,
    output logic [stsi_pkg::POS_W-1:0]          o_position,
    output logic [stsi_pkg::COUNT_W-1:0]        o_entry_count,
    output logic                                o_is_empty,
    output logic signed [stsi_pkg::VAL_W-1:0]   o_smallest,
    output logic signed [stsi_pkg::VAL_W-1:0]   o_largest
);
    import stsi_pkg::*;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int PW    = (IDX_W > POS_W) ? IDX_W : POS_W;
    localparam int CW    = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(CAPACITY);

    // Sequencer phases
    localparam logic [1:0] PH_CMP   = 2'd0;
    localparam logic [1:0] PH_ENC   = 2'd1;
    localparam logic [1:0] PH_SHIFT = 2'd2;
    localparam logic [1:0] PH_OUT   = 2'd3;

    logic                    r_busy;
    logic [1:0]              r_phase;
    logic [REQ_W-1:0]        r_req;
    logic signed [VAL_W-1:0] r_value;
    logic [CNT_W-1:0]        r_count;
    logic [STAT_W-1:0]       r_status;
    logic [IDX_W-1:0]        r_pos;
    logic                    r_do_ins;
    logic                    r_do_del;

    logic                    r_out_valid;
    logic [STAT_W-1:0]       r_out_status;
    logic [POS_W-1:0]        r_out_pos;
    logic [COUNT_W-1:0]      r_out_count;
    logic                    r_out_empty;
    logic signed [VAL_W-1:0] r_out_small;
    logic signed [VAL_W-1:0] r_out_large;

    t_cell_ctrl              w_ctrl;
    t_cell_stat              w_stat       [CAPACITY];
    t_cell_stat              w_left_stat  [CAPACITY];
    logic signed [VAL_W-1:0] w_entry      [CAPACITY];
    logic signed [VAL_W-1:0] w_left_entry [CAPACITY];
    logic signed [VAL_W-1:0] w_right_entry[CAPACITY];
    logic                    w_last       [CAPACITY];

    logic [IDX_W-1:0]        w_enc_pos;
    logic                    w_found;
    logic signed [VAL_W-1:0] w_largest;
    logic                    w_accept;
    logic [PW-1:0]           w_pos_ext;
    logic [CW-1:0]           w_cnt_ext;

    assign w_accept = start && !r_busy;

    // Broadcast control
    always_comb begin
        w_ctrl.cmp_en    = r_busy && (r_phase == PH_CMP);
        w_ctrl.is_ins    = (r_req == REQ_INSERT);
        w_ctrl.shift_ins = r_busy && (r_phase == PH_SHIFT) && r_do_ins;
        w_ctrl.shift_del = r_busy && (r_phase == PH_SHIFT) && r_do_del;
        w_ctrl.value     = r_value;
    end

    // Cell row with neighbour links
    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
        if (gi == 0) begin : g_first
            assign w_left_stat[gi]  = '{lt: 1'b1, le: 1'b1, hot: 1'b0, match: 1'b0};
            assign w_left_entry[gi] = '0;
        end else begin : g_inner
            assign w_left_stat[gi]  = w_stat[gi-1];
            assign w_left_entry[gi] = w_entry[gi-1];
        end
        if (gi == CAPACITY - 1) begin : g_end
            assign w_right_entry[gi] = '0;
        end else begin : g_mid
            assign w_right_entry[gi] = w_entry[gi+1];
        end

        stsi_cell #(
            .CNT_W    (CNT_W),
            .CELL_IDX (gi)
        ) u_cell (
            .i_clk         (i_clk),
            .i_ctrl        (w_ctrl),
            .i_count       (r_count),
            .i_left_stat   (w_left_stat[gi]),
            .i_left_entry  (w_left_entry[gi]),
            .i_right_entry (w_right_entry[gi]),
            .o_stat        (w_stat[gi]),
            .o_entry       (w_entry[gi]),
            .o_last        (w_last[gi])
        );
    end

    // One-hot boundary to index, match flag and last-entry select
    always_comb begin
        w_enc_pos = '0;
        w_found   = 1'b0;
        w_largest = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (w_stat[i].hot) begin
                w_enc_pos = w_enc_pos | IDX_W'(i);
            end
            w_found = w_found | w_stat[i].match;
            if (w_last[i]) begin
                w_largest = w_largest | w_entry[i];
            end
        end
    end

    // Sequencer and table count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_phase <= PH_CMP;
            r_count <= '0;
        end else begin
            if (w_accept) begin
                r_busy  <= 1'b1;
                r_phase <= PH_CMP;
            end else if (r_busy) begin
                r_phase <= r_phase + 2'd1;
                if (r_phase == PH_OUT) begin
                    r_busy <= 1'b0;
                end
            end
            if (w_ctrl.shift_ins) begin
                r_count <= r_count + CNT_W'(1);
            end else if (w_ctrl.shift_del) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    // Request capture
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req   <= i_req_type;
            r_value <= i_value;
        end
    end

    // Decide the outcome from the cell flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_do_ins <= 1'b0;
            r_do_del <= 1'b0;
        end else if (r_busy && (r_phase == PH_ENC)) begin
            r_do_ins <= 1'b0;
            r_do_del <= 1'b0;
            case (r_req)
                REQ_INSERT: begin
                    if (r_count < FULL_COUNT) begin
                        r_status <= ST_OK;
                        r_pos    <= w_enc_pos;
                        r_do_ins <= 1'b1;
                    end else begin
                        r_status <= ST_FULL;
                        r_pos    <= '0;
                    end
                end
                REQ_DELETE: begin
                    r_status <= w_found ? ST_OK : ST_MISSING;
                    r_pos    <= w_found ? w_enc_pos : '0;
                    r_do_del <= w_found;
                end
                default: begin
                    r_status <= w_found ? ST_OK : ST_MISSING;
                    r_pos    <= w_found ? w_enc_pos : '0;
                end
            endcase
        end
    end

    assign w_pos_ext = PW'(r_pos);
    assign w_cnt_ext = CW'(r_count);

    // Result registers and strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_busy && (r_phase == PH_OUT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy && (r_phase == PH_OUT)) begin
            r_out_status <= r_status;
            r_out_pos    <= w_pos_ext[POS_W-1:0];
            r_out_count  <= w_cnt_ext[COUNT_W-1:0];
            r_out_empty  <= (r_count == '0);
            r_out_small  <= (r_count == '0) ? '0 : w_entry[0];
            r_out_large  <= w_largest;
        end
    end

    assign busy          = r_busy;
    assign o_valid       = r_out_valid;
    assign o_status      = r_out_status;
    assign o_position    = r_out_pos;
    assign o_entry_count = r_out_count;
    assign o_is_empty    = r_out_empty;
    assign o_smallest    = r_out_small;
    assign o_largest     = r_out_large;

endmodule

@@ rtl/stsi_cell.sv @@
// One table cell: holds an entry, registers its compare flags and shifts on request.
`timescale 1ns / 1ps

module stsi_cell #(
    parameter int CNT_W    = 8,
    parameter int CELL_IDX = 0
) (
    input  logic                             i_clk,
    input  stsi_pkg::t_cell_ctrl             i_ctrl,
    input  logic [CNT_W-1:0]                 i_count,
    input  stsi_pkg::t_cell_stat             i_left_stat,
    input  logic signed [stsi_pkg::VAL_W-1:0] i_left_entry,
    input  logic signed [stsi_pkg::VAL_W-1:0] i_right_entry,
    output stsi_pkg::t_cell_stat             o_stat,
    output logic signed [stsi_pkg::VAL_W-1:0] o_entry,
    output logic                             o_last
);
    import stsi_pkg::*;

    localparam logic [CNT_W-1:0] MY_IDX  = CNT_W'(CELL_IDX);
    localparam logic [CNT_W-1:0] MY_NEXT = CNT_W'(CELL_IDX + 1);

    logic signed [VAL_W-1:0] r_entry;
    logic                    r_lt;
    logic                    r_le;
    logic                    r_eq;
    logic                    w_occ;

    // Cell is occupied when it sits below the count
    assign w_occ = MY_IDX < i_count;

    // Compare flags, taken once per request
    always_ff @(posedge i_clk) begin
        if (i_ctrl.cmp_en) begin
            r_lt <= w_occ && (r_entry < i_ctrl.value);
            r_le <= w_occ && (r_entry <= i_ctrl.value);
            r_eq <= w_occ && (r_entry == i_ctrl.value);
        end
    end

    // Entry shifts: up on insert above the boundary, down on delete from it
    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift_ins && !r_le) begin
            r_entry <= i_left_stat.le ? i_ctrl.value : i_left_entry;
        end else if (i_ctrl.shift_del && !r_lt) begin
            r_entry <= i_right_entry;
        end
    end

    // Boundary: first cell whose flag drops
    always_comb begin
        o_stat.lt    = r_lt;
        o_stat.le    = r_le;
        o_stat.hot   = i_ctrl.is_ins ? (!r_le && i_left_stat.le) : (!r_lt && i_left_stat.lt);
        o_stat.match = o_stat.hot && r_eq;
    end

    assign o_entry = r_entry;
    assign o_last  = (MY_NEXT == i_count);

endmodule
